FILE: src/ihc_pkg.sv
// Shared types and constants for the InSAR phase HSV colorizer.
// Holds the configuration record, the queued pixel record and register indexes.
// No dependencies.
package ihc_pkg;

  localparam int NUM_SEGMENTS_DEF = 3;
  localparam int MAX_COLUMNS_DEF = 16384;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] REG_USE_COHERENCE = 3'd0;
  localparam logic [2:0] REG_SEGMENT_ONE_START = 3'd1;
  localparam logic [2:0] REG_SEGMENT_TWO_START = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
  localparam logic [2:0] REG_STRETCH_ZERO = 3'd4;
  localparam logic [2:0] REG_STRETCH_ONE = 3'd5;
  localparam logic [2:0] REG_STRETCH_TWO = 3'd6;

  localparam logic [1:0] SEG_ZERO = 2'd0;
  localparam logic [1:0] SEG_ONE = 2'd1;
  localparam logic [1:0] SEG_TWO = 2'd2;

  localparam logic [2:0] SEC_RED_UP = 3'd0;
  localparam logic [2:0] SEC_GREEN_MAX = 3'd1;
  localparam logic [2:0] SEC_BLUE_UP = 3'd2;
  localparam logic [2:0] SEC_BLUE_MAX = 3'd3;
  localparam logic [2:0] SEC_RED_DOWN = 3'd4;

  localparam logic [29:0] HUE_K = 30'd683565276;
  localparam logic [29:0] LOG10_HALF_K = 30'd646456993;

  localparam logic [13:0] SEG_START_RESET = 14'd16383;
  localparam logic [14:0] WIDTH_RESET = 15'd16384;
  localparam logic [63:0] STRETCH_RESET = 64'd65536;

  typedef struct packed {
    logic        use_coherence;
    logic [13:0] segment_one_start;
    logic [13:0] segment_two_start;
    logic [14:0] image_width;
    logic [63:0] stretch_zero;
    logic [63:0] stretch_one;
    logic [63:0] stretch_two;
  } cfg_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat;
    logic [1:0]  seg;
    logic        blank;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    logic signed [23:0] ifg_real;
    logic signed [23:0] ifg_imag;
  } item_t;

endpackage

FILE: src/insar_phase_hsv_colorizer.sv
// Top level of the InSAR phase HSV colorizer: configuration registers,
// front end, request queue and back-end pipeline.
// Depends on ihc_pkg, ihc_front, ihc_queue and ihc_back.
//
// Pixels enter on the in_valid/in_ready channel, one request per pixel, and
// each gives one RGB triple on the out_valid/out_ready channel, in order.
// The front end classifies a pixel in the cycle it is accepted and writes it
// into a four-entry queue. The back end is a 26-stage pipeline (power,
// leading-one search, normalization, sixteen squaring stages for the log2
// fraction, log10 scaling, stretch, clamp, two sextant stages and the byte
// rounding). Throughput is one pixel per clock while out_ready stays high.
// When the receiver stalls, the whole back-end pipeline holds and the queue
// keeps accepting until it is full; in_ready then falls.
// Reset (synchronous, active high) empties the queue and the pipeline and
// loads the default register values. Registers are written through
// cfg_write, cfg_index and cfg_data and should change only while idle.
module insar_phase_hsv_colorizer import ihc_pkg::*; #(
  parameter int NUM_SEGMENTS = NUM_SEGMENTS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        column,
  input  logic signed [15:0] phase,
  input  logic signed [23:0] ifg_real,
  input  logic signed [23:0] ifg_imag,
  input  logic [15:0]        coherence,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  cfg_t  cfg;
  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_coherence <= 1'b0;
      cfg.segment_one_start <= SEG_START_RESET;
      cfg.segment_two_start <= SEG_START_RESET;
      cfg.image_width <= WIDTH_RESET;
      cfg.stretch_zero <= STRETCH_RESET;
      cfg.stretch_one <= STRETCH_RESET;
      cfg.stretch_two <= STRETCH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_USE_COHERENCE: cfg.use_coherence <= cfg_data[0];
        REG_SEGMENT_ONE_START: cfg.segment_one_start <= cfg_data[13:0];
        REG_SEGMENT_TWO_START: cfg.segment_two_start <= cfg_data[13:0];
        REG_IMAGE_WIDTH: cfg.image_width <= cfg_data[14:0];
        REG_STRETCH_ZERO: cfg.stretch_zero <= cfg_data;
        REG_STRETCH_ONE: cfg.stretch_one <= cfg_data;
        REG_STRETCH_TWO: cfg.stretch_two <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ihc_front #(
    .NUM_SEGMENTS(NUM_SEGMENTS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .cfg(cfg),
    .column(column),
    .phase(phase),
    .ifg_real(ifg_real),
    .ifg_imag(ifg_imag),
    .coherence(coherence),
    .item(front_item)
  );

  ihc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_valid),
    .push_item(front_item),
    .ready(in_ready),
    .pop(q_pop),
    .valid(q_valid),
    .pop_item(q_item)
  );

  ihc_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red(red),
    .green(green),
    .blue(blue)
  );

endmodule

FILE: src/ihc_front.sv
// Front end: classifies one pixel into hue, saturation, segment and blanking.
// Depends on ihc_pkg.
module ihc_front import ihc_pkg::*; #(
  parameter int NUM_SEGMENTS = NUM_SEGMENTS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  cfg_t               cfg,
  input  logic [13:0]        column,
  input  logic signed [15:0] phase,
  input  logic signed [23:0] ifg_real,
  input  logic signed [23:0] ifg_imag,
  input  logic [15:0]        coherence,
  output item_t              item
);

  localparam logic [16:0] MAX_COLS = 17'(MAX_COLUMNS);

  logic signed [46:0] hue_prod;
  logic [43:0]        hue_sum;
  logic [18:0]        sat_num;
  logic [37:0]        sat_prod;

  assign hue_prod = $signed(phase) * $signed({1'b0, HUE_K});
  assign hue_sum = hue_prod[43:0] + 44'h800_0000_0000 + 44'h000_0800_0000;
  assign sat_num = 19'd65538 + {1'b0, coherence, 2'b00};
  assign sat_prod = 38'(sat_num) * 38'd419431;

  always_comb begin
    item.meta.hue = hue_sum[43:28];
    item.meta.sat = cfg.use_coherence ? sat_prod[37:21] : 17'd65536;
    item.meta.blank = ({3'b000, column} >= {2'b00, cfg.image_width}) ||
                      ({3'b000, column} >= MAX_COLS);
    if (NUM_SEGMENTS >= 3 && column >= cfg.segment_two_start) begin
      item.meta.seg = SEG_TWO;
    end else if (NUM_SEGMENTS >= 2 && column >= cfg.segment_one_start) begin
      item.meta.seg = SEG_ONE;
    end else begin
      item.meta.seg = SEG_ZERO;
    end
    item.ifg_real = ifg_real;
    item.ifg_imag = ifg_imag;
  end

endmodule

FILE: src/ihc_queue.sv
// Short request queue between the front end and the back-end pipeline.
// Depends on ihc_pkg.
module ihc_queue import ihc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign ready = count != CW'(DEPTH);
  assign valid = count != '0;
  assign pop_item = mem[rd_ptr];
  assign do_push = push && ready;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

FILE: src/ihc_back.sv
// Back-end pipeline: power, log2 by squaring, value stretch, sextant conversion.
// Depends on ihc_pkg.
module ihc_back import ihc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  localparam int NST = 26;

  logic [NST-1:0] vld;
  logic           adv;
  meta_t          meta [23];
  meta_t          meta_c;

  logic signed [47:0] re2;
  logic signed [47:0] im2;
  logic [47:0]        pw0;
  logic [47:0]        pw1;
  logic [5:0]         k1;
  logic [5:0]         k_c;
  logic [47:0]        xs;
  logic [30:0]        xq [17];
  logic [15:0]        fq [17];
  logic [5:0]         kq [17];
  logic [61:0]        sqr [16];
  logic [30:0]        nxq [16];
  logic [15:0]        nfq [16];
  logic [51:0]        lg_prod;
  logic [19:0]        lg;
  logic [63:0]        st;
  logic signed [33:0] dd;
  logic [31:0]        dmag;
  logic [31:0]        rspan;
  logic               dpos;
  logic [63:0]        prodm;
  logic               posm;
  logic [64:0]        rv;
  logic [16:0]        vv;
  logic [18:0]        h6;
  logic [2:0]         sec;
  logic [32:0]        sf;
  logic [32:0]        sfc;
  logic [48:0]        pa;
  logic [16:0]        va;
  logic [49:0]        q_full;
  logic [49:0]        t_full;
  logic [48:0]        v48;
  logic [48:0]        r48;
  logic [48:0]        g48;
  logic [48:0]        b48;
  logic [56:0]        rb;
  logic [56:0]        gb;
  logic [56:0]        bb;

  assign adv = !(vld[NST-1] && !out_ready);
  assign q_pop = q_valid && adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], q_valid};
    end
  end

  assign re2 = q_item.ifg_real * q_item.ifg_real;
  assign im2 = q_item.ifg_imag * q_item.ifg_imag;

  always_comb begin
    meta_c = meta[0];
    meta_c.blank = meta[0].blank || (pw0 == '0);
    k_c = '0;
    for (int i = 0; i < 48; i++) begin
      if (pw0[i]) begin
        k_c = 6'(i);
      end
    end
    if (k1 >= 6'd30) begin
      xs = pw1 >> (k1 - 6'd30);
    end else begin
      xs = pw1 << (6'd30 - k1);
    end
    for (int j = 0; j < 16; j++) begin
      sqr[j] = 62'(xq[j]) * 62'(xq[j]);
      if (sqr[j][61]) begin
        nxq[j] = sqr[j][61:31];
        nfq[j] = {fq[j][14:0], 1'b1};
      end else begin
        nxq[j] = sqr[j][60:30];
        nfq[j] = {fq[j][14:0], 1'b0};
      end
    end
    lg_prod = 52'({kq[16], fq[16]}) * 52'(LOG10_HALF_K) + 52'h0_0000_8000_0000;
    case (meta[19].seg)
      SEG_TWO: st = cfg.stretch_two;
      SEG_ONE: st = cfg.stretch_one;
      default: st = cfg.stretch_zero;
    endcase
    dd = $signed({14'b0, lg}) - $signed({{2{st[63]}}, st[63:32]});
    rv = {1'b0, prodm} + 65'd32768;
    h6 = 19'(meta[22].hue) * 19'd6;
    q_full = 50'(va) * 50'(33'h1_0000_0000 - sf);
    t_full = 50'(va) * 50'(33'h1_0000_0000 - sfc);
    v48 = {va, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= q_item.meta;
      pw0 <= 48'(re2) + 48'(im2);
      meta[1] <= meta_c;
      pw1 <= pw0;
      k1 <= k_c;
      for (int i = 2; i < 23; i++) begin
        meta[i] <= meta[i-1];
      end
      xq[0] <= xs[30:0];
      fq[0] <= '0;
      kq[0] <= k1;
      for (int j = 0; j < 16; j++) begin
        xq[j+1] <= nxq[j];
        fq[j+1] <= nfq[j];
        kq[j+1] <= kq[j];
      end
      lg <= lg_prod[51:32];
      dpos <= !dd[33] && (dd != '0);
      dmag <= dd[31:0];
      rspan <= st[31:0];
      prodm <= 64'(dmag) * 64'(rspan);
      posm <= dpos;
      if (!posm || meta[21].blank) begin
        vv <= '0;
      end else if (rv[64:16] > 49'd65536) begin
        vv <= 17'd65536;
      end else begin
        vv <= rv[32:16];
      end
      sec <= h6[18:16];
      sf <= 33'(meta[22].sat) * 33'(h6[15:0]);
      sfc <= 33'(meta[22].sat) * 33'(17'd65536 - {1'b0, h6[15:0]});
      pa <= {33'(vv) * 33'(17'd65536 - meta[22].sat), 16'b0};
      va <= vv;
      case (sec)
        SEC_RED_UP: begin
          r48 <= v48; g48 <= t_full[48:0]; b48 <= pa;
        end
        SEC_GREEN_MAX: begin
          r48 <= q_full[48:0]; g48 <= v48; b48 <= pa;
        end
        SEC_BLUE_UP: begin
          r48 <= pa; g48 <= v48; b48 <= t_full[48:0];
        end
        SEC_BLUE_MAX: begin
          r48 <= pa; g48 <= q_full[48:0]; b48 <= v48;
        end
        SEC_RED_DOWN: begin
          r48 <= t_full[48:0]; g48 <= pa; b48 <= v48;
        end
        default: begin
          r48 <= v48; g48 <= pa; b48 <= q_full[48:0];
        end
      endcase
      red <= rb[55:48];
      green <= gb[55:48];
      blue <= bb[55:48];
    end
  end

  assign rb = {r48, 8'b0} - 57'(r48) + 57'h0_8000_0000_0000;
  assign gb = {g48, 8'b0} - 57'(g48) + 57'h0_8000_0000_0000;
  assign bb = {b48, 8'b0} - 57'(b48) + 57'h0_8000_0000_0000;

endmodule

FILE: tb/insar_phase_hsv_colorizer_tb.sv
// Self-checking testbench for the InSAR phase HSV colorizer: directed pixels, then
// random pixels under several register settings, checked against an in-bench predictor.
// Depends on ihc_pkg and insar_phase_hsv_colorizer.
module insar_phase_hsv_colorizer_tb import ihc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PIPE_DRAIN = 40;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [13:0]        col;
    logic signed [15:0] ph;
    logic signed [23:0] re;
    logic signed [23:0] im;
    logic [15:0]        coh;
    logic               known;
    rgb_t               rgb;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [13:0] column = '0;
  logic signed [15:0] phase = '0;
  logic signed [23:0] ifg_real = '0;
  logic signed [23:0] ifg_imag = '0;
  logic [15:0] coherence = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red, green, blue;

  cfg_t model_cfg;
  rgb_t pending_rgb[$];
  int sent = 0;
  int fails = 0;
  int send_idle = 29;
  int recv_idle = 78;
  logic hold = 1'b0;

  insar_phase_hsv_colorizer dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("insar_phase_hsv_colorizer_tb: FAIL");
    $finish;
  end

  function automatic rgb_t colorize(input logic [13:0] col, input logic signed [15:0] ph,
                                    input logic signed [23:0] re,
                                    input logic signed [23:0] im, input logic [15:0] coh);
    longint hp, d, lo;
    logic [63:0] hu, pw, x, frac, lg, v, s, h6, f, width, st, rspan, sec;
    logic [63:0] v48, p48, q48, t48, rr, gg, bb, tmp;
    int k;
    rgb_t o;
    hp = longint'(ph) * longint'(HUE_K);
    hu = hp + 64'h0000_0800_0800_0000;
    s = model_cfg.use_coherence ? (64'd65536 + 64'd4 * coh + 64'd2) / 64'd5 : 64'd65536;
    width = 64'(model_cfg.image_width);
    if (width > 64'(MAX_COLUMNS_DEF)) width = 64'(MAX_COLUMNS_DEF);
    pw = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    v = '0;
    if (pw != 0 && 64'(col) < width) begin
      k = 0;
      while (k < 63 && (pw >> (k + 1)) != 0) k++;
      x = (k >= 30) ? pw >> (k - 30) : pw << (30 - k);
      frac = '0;
      repeat (16) begin
        x = (x * x) >> 30;
        frac = frac << 1;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          frac = frac | 64'd1;
        end
      end
      lg = (((64'(k) << 16) | frac) * 64'(LOG10_HALF_K) + (64'd1 << 31)) >> 32;
      if (col >= model_cfg.segment_two_start) st = model_cfg.stretch_two;
      else if (col >= model_cfg.segment_one_start) st = model_cfg.stretch_one;
      else st = model_cfg.stretch_zero;
      lo = longint'(signed'(st[63:32]));
      rspan = 64'(st[31:0]);
      d = longint'(lg) - lo;
      if (d > 0) begin
        v = (64'(d) * rspan + 64'd32768) >> 16;
        if (v > 64'd65536) v = 64'd65536;
      end
    end
    h6 = 64'(hu[43:28]) * 64'd6;
    sec = h6 >> 16;
    f = h6 & 64'hFFFF;
    v48 = v << 32;
    p48 = (v * (64'd65536 - s)) << 16;
    q48 = v * ((64'd1 << 32) - s * f);
    t48 = v * ((64'd1 << 32) - s * (64'd65536 - f));
    case (sec[2:0])
      SEC_RED_UP: begin rr = v48; gg = t48; bb = p48; end
      SEC_GREEN_MAX: begin rr = q48; gg = v48; bb = p48; end
      SEC_BLUE_UP: begin rr = p48; gg = v48; bb = t48; end
      SEC_BLUE_MAX: begin rr = p48; gg = q48; bb = v48; end
      SEC_RED_DOWN: begin rr = t48; gg = p48; bb = v48; end
      default: begin rr = v48; gg = p48; bb = q48; end
    endcase
    tmp = rr * 64'd255 + (64'd1 << 47);
    o.r = tmp[55:48];
    tmp = gg * 64'd255 + (64'd1 << 47);
    o.g = tmp[55:48];
    tmp = bb * 64'd255 + (64'd1 << 47);
    o.b = tmp[55:48];
    return o;
  endfunction

  // The caller lowers cfg_write after the last write of a batch.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_USE_COHERENCE: model_cfg.use_coherence = data[0];
      REG_SEGMENT_ONE_START: model_cfg.segment_one_start = data[13:0];
      REG_SEGMENT_TWO_START: model_cfg.segment_two_start = data[13:0];
      REG_IMAGE_WIDTH: model_cfg.image_width = data[14:0];
      REG_STRETCH_ZERO: model_cfg.stretch_zero = data;
      REG_STRETCH_ONE: model_cfg.stretch_one = data;
      REG_STRETCH_TWO: model_cfg.stretch_two = data;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t p);
    rgb_t want_rgb;
    column <= p.col;
    phase <= p.ph;
    ifg_real <= p.re;
    ifg_imag <= p.im;
    coherence <= p.coh;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    want_rgb = p.known ? p.rgb : colorize(p.col, p.ph, p.re, p.im, p.coh);
    pending_rgb = {pending_rgb, want_rgb};
    sent++;
    if (sent == 420) begin
      send_idle = 78;
      recv_idle = 29;
    end else if (sent == 840) begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [63:0] random_stretch;
    logic [31:0] lo;
    logic [31:0] rspan;
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    lo = $urandom_range(6 * 65536);
    if ($urandom_range(3) == 0) lo = -lo;
    rspan = $urandom_range(300000, 4096);
    return {lo, rspan};
  endfunction

  function automatic pixel_t random_pixel;
    pixel_t p;
    p = '0;
    p.col = 14'($urandom);
    p.ph = 16'($urandom);
    p.re = signed'(24'($urandom)) >>> $urandom_range(23);
    p.im = signed'(24'($urandom)) >>> $urandom_range(23);
    if ($urandom_range(19) == 0) begin
      p.re = '0;
      p.im = '0;
    end
    p.coh = 16'($urandom);
    return p;
  endfunction

  always @(posedge clk) begin : result_check
    rgb_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_rgb.size() == 0) begin
          $display("%0t: unexpected result %0d %0d %0d", $time, red, green, blue);
          fails++;
        end else begin
          want = pending_rgb.pop_front();
          if (red !== want.r) begin
            $display("%0t: red expected %0d actual %0d", $time, want.r, red);
            fails++;
          end
          if (green !== want.g) begin
            $display("%0t: green expected %0d actual %0d", $time, want.g, green);
            fails++;
          end
          if (blue !== want.b) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.b, blue);
            fails++;
          end
        end
      end
      out_ready <= !hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // A long receiver stall while the sender keeps offering fills the queue.
  initial begin
    wait (sent == 150);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    pixel_t directed[14];
    int n;
    directed = '{
      '{14'd0, 16'sd0, 24'sd1000, 24'sd0, 16'd0, 1'b1, '{8'd0, 8'd255, 8'd255}},
      '{14'd5, 16'sd12345, 24'sd0, 24'sd0, 16'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{14'd16383, 16'sd0, 24'sd1000, 24'sd0, 16'd0, 1'b1, '{8'd0, 8'd255, 8'd255}},
      '{14'd7, 16'sd0, 24'sd0, 24'sd1000, 16'd65535, 1'b1, '{8'd0, 8'd255, 8'd255}},
      '{14'd9, -16'sd700, 24'sd1, 24'sd0, 16'd0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{14'd100, 16'sd32767, 24'sd8388607, 24'sd8388607, 16'd0, 1'b0, '0},
      '{14'd200, -16'sd32768, -24'sd8388608, -24'sd8388608, 16'd65535, 1'b0, '0},
      '{14'd300, -16'sd10000, 24'sd5000, -24'sd3000, 16'd1000, 1'b0, '0},
      '{14'd400, -16'sd6000, 24'sd5000, -24'sd3000, 16'd1000, 1'b0, '0},
      '{14'd500, -16'sd2000, 24'sd5000, -24'sd3000, 16'd1000, 1'b0, '0},
      '{14'd600, 16'sd2000, 24'sd5000, -24'sd3000, 16'd1000, 1'b0, '0},
      '{14'd700, 16'sd6000, 24'sd5000, -24'sd3000, 16'd1000, 1'b0, '0},
      '{14'd800, 16'sd10000, 24'sd3, 24'sd2, 16'd1000, 1'b0, '0},
      '{14'd16382, 16'sd12867, -24'sd1, 24'sd8388607, 16'd0, 1'b0, '0}
    };
    model_cfg = '{1'b0, SEG_START_RESET, SEG_START_RESET, WIDTH_RESET,
                  STRETCH_RESET, STRETCH_RESET, STRETCH_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_USE_COHERENCE, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_SEGMENT_ONE_START, 64'd16383);
          write_reg(REG_SEGMENT_TWO_START, 64'd0);
          write_reg(REG_IMAGE_WIDTH, 64'd0);
          write_reg(REG_STRETCH_ZERO, 64'd0);
          write_reg(REG_STRETCH_ONE, 64'd0);
          write_reg(REG_STRETCH_TWO, 64'd0);
          write_reg(REG_UNUSED, 64'h1234_5678_9ABC_DEF0);
        end
        1: begin
          write_reg(REG_USE_COHERENCE, 64'hFFFF_FFFF_FFFF_FFFE);
          write_reg(REG_SEGMENT_ONE_START, 64'hFFFF_FFFF_FFFF_C000);
          write_reg(REG_SEGMENT_TWO_START, 64'd16383);
          write_reg(REG_IMAGE_WIDTH, 64'd32767);
          write_reg(REG_STRETCH_ZERO, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(REG_STRETCH_ONE, 64'h8000_0000_FFFF_FFFF);
          write_reg(REG_STRETCH_TWO, 64'd0);
        end
        default: begin
          write_reg(REG_USE_COHERENCE, 64'($urandom_range(1)));
          write_reg(REG_SEGMENT_ONE_START, 64'($urandom_range(16383)));
          write_reg(REG_SEGMENT_TWO_START, 64'($urandom_range(16383)));
          write_reg(REG_IMAGE_WIDTH, 64'($urandom_range(16384, 1)));
          write_reg(REG_STRETCH_ZERO, random_stretch());
          write_reg(REG_STRETCH_ONE, random_stretch());
          write_reg(REG_STRETCH_TWO, random_stretch());
        end
      endcase
      cfg_write <= 1'b0;
      @(posedge clk);
      n = (ph == 0) ? 100 : (ph == 1) ? 250 : 300;
      repeat (n) send_pixel(random_pixel());
      drain();
    end

    if (fails == 0) begin
      $display("insar_phase_hsv_colorizer_tb: PASS");
    end else begin
      $display("insar_phase_hsv_colorizer_tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: insar_phase_hsv_colorizer.f
src/ihc_pkg.sv
src/ihc_front.sv
src/ihc_queue.sv
src/ihc_back.sv
src/insar_phase_hsv_colorizer.sv
tb/insar_phase_hsv_colorizer_tb.sv
